FILE: design/point_triangle_squared_distance_core_defines.svh
// assertion macros for the point-triangle distance core
`ifndef POINT_TRIANGLE_SQUARED_DISTANCE_CORE_DEFINES_SVH
`define POINT_TRIANGLE_SQUARED_DISTANCE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PTSD_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

`define PTSD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define PTSD_ASSERT(name, expr)
`define PTSD_ASSERT_IMPL(name, ante, cons)

`endif

`endif

FILE: design/ptsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptsd_pkg;

  localparam int OUT_BITS = 34;
  localparam int OUT_FRAC = 16;

  typedef enum logic [2:0] {
    REG_FACE   = 3'd0,
    REG_EDGE12 = 3'd1,
    REG_VERT2  = 3'd2,
    REG_EDGE02 = 3'd3,
    REG_VERT0  = 3'd4,
    REG_EDGE01 = 3'd5,
    REG_VERT1  = 3'd6
  } region_e;

  // sign and magnitude tests that steer the region decision
  typedef struct packed {
    logic st_le;
    logic det_zero;
    logic a00_le_nb0;
    logic a11_le_nb1;
    logic r2_lt;
    logic r2_t1_le0;
    logic r2_dn_le;
    logic r6_lt;
    logic r6_t1_le0;
    logic r6_dn_le;
    logic r1_num_le0;
    logic r1_dn_le;
  } cmp_t;

  typedef struct packed {
    region_e region;
    logic    degenerate;
  } info_t;

endpackage

`default_nettype wire

FILE: design/ptsd_setup.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsd_setup #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] v0_x_i,
  input  logic signed [COORD_WIDTH-1:0] v0_y_i,
  input  logic signed [COORD_WIDTH-1:0] v0_z_i,
  input  logic signed [COORD_WIDTH-1:0] v1_x_i,
  input  logic signed [COORD_WIDTH-1:0] v1_y_i,
  input  logic signed [COORD_WIDTH-1:0] v1_z_i,
  input  logic signed [COORD_WIDTH-1:0] v2_x_i,
  input  logic signed [COORD_WIDTH-1:0] v2_y_i,
  input  logic signed [COORD_WIDTH-1:0] v2_z_i,
  output logic                         valid_o,
  output ptsd_pkg::cmp_t               cmp_o,
  output logic signed [2*(COORD_WIDTH+1)+2-1:0] a00_o,
  output logic signed [2*(COORD_WIDTH+1)+2-1:0] a11_o,
  output logic signed [2*(COORD_WIDTH+1)+2-1:0] b0_o,
  output logic signed [2*(COORD_WIDTH+1)+2-1:0] b1_o,
  output logic signed [2*(COORD_WIDTH+1)+2-1:0] c_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] q10_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] q01_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] dn_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] r2num_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] r6num_o,
  output logic signed [2*(COORD_WIDTH+1)+4-1:0] r1num_o,
  output logic signed [2*(2*(COORD_WIDTH+1)+2):0] det_o,
  output logic signed [2*(2*(COORD_WIDTH+1)+2):0] s_o,
  output logic signed [2*(2*(COORD_WIDTH+1)+2):0] t_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PRW  = 2 * DW;
  localparam int DOTW = PRW + 2;
  localparam int AW   = DOTW + 2;
  localparam int MW   = 2 * DOTW;
  localparam int WW   = MW + 1;
  localparam int NST  = 6;

  // dot product slots
  localparam int IA00 = 0;
  localparam int IA01 = 1;
  localparam int IA11 = 2;
  localparam int IB0  = 3;
  localparam int IB1  = 4;
  localparam int IC   = 5;

  logic [NST-1:0] v_q;

  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] v0 [3];
  logic signed [CW-1:0] v1 [3];
  logic signed [CW-1:0] v2 [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign v0[0] = v0_x_i;
  assign v0[1] = v0_y_i;
  assign v0[2] = v0_z_i;
  assign v1[0] = v1_x_i;
  assign v1[1] = v1_y_i;
  assign v1[2] = v1_z_i;
  assign v2[0] = v2_x_i;
  assign v2[1] = v2_y_i;
  assign v2[2] = v2_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = v_q[NST-1];

  // stage 1: edges and offset
  logic signed [DW-1:0] e0_q [3];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] df_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e0_q[k] <= DW'(v1[k]) - DW'(v0[k]);
        e1_q[k] <= DW'(v2[k]) - DW'(v0[k]);
        df_q[k] <= DW'(v0[k]) - DW'(pt[k]);
      end
    end
  end

  // stage 2: component products
  logic signed [PRW-1:0] pr_q [6][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[IA00][k] <= PRW'(e0_q[k]) * PRW'(e0_q[k]);
        pr_q[IA01][k] <= PRW'(e0_q[k]) * PRW'(e1_q[k]);
        pr_q[IA11][k] <= PRW'(e1_q[k]) * PRW'(e1_q[k]);
        pr_q[IB0][k]  <= PRW'(df_q[k]) * PRW'(e0_q[k]);
        pr_q[IB1][k]  <= PRW'(df_q[k]) * PRW'(e1_q[k]);
        pr_q[IC][k]   <= PRW'(df_q[k]) * PRW'(df_q[k]);
      end
    end
  end

  // stage 3: dot products
  logic signed [DOTW-1:0] dot_q [6];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) begin
        dot_q[i] <= DOTW'(pr_q[i][0]) + DOTW'(pr_q[i][1]) + DOTW'(pr_q[i][2]);
      end
    end
  end

  // stage 4: cross products and edge helper sums
  logic signed [MW-1:0]   m_q [6];
  logic signed [AW-1:0]   q10_s4_q, q01_s4_q, dn_s4_q, r1num_s4_q;
  logic signed [AW-1:0]   r2t0_q, r2t1_q, r6t0_q, r6t1_q;
  logic signed [DOTW-1:0] a00_s4_q, a11_s4_q, b0_s4_q, b1_s4_q, c_s4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]     <= MW'(dot_q[IA00]) * MW'(dot_q[IA11]);
      m_q[1]     <= MW'(dot_q[IA01]) * MW'(dot_q[IA01]);
      m_q[2]     <= MW'(dot_q[IA01]) * MW'(dot_q[IB1]);
      m_q[3]     <= MW'(dot_q[IA11]) * MW'(dot_q[IB0]);
      m_q[4]     <= MW'(dot_q[IA01]) * MW'(dot_q[IB0]);
      m_q[5]     <= MW'(dot_q[IA00]) * MW'(dot_q[IB1]);
      q10_s4_q   <= AW'(dot_q[IA00]) + (AW'(dot_q[IB0]) <<< 1) + AW'(dot_q[IC]);
      q01_s4_q   <= AW'(dot_q[IA11]) + (AW'(dot_q[IB1]) <<< 1) + AW'(dot_q[IC]);
      dn_s4_q    <= AW'(dot_q[IA00]) - (AW'(dot_q[IA01]) <<< 1) + AW'(dot_q[IA11]);
      r1num_s4_q <= AW'(dot_q[IA11]) + AW'(dot_q[IB1]) - AW'(dot_q[IA01])
                    - AW'(dot_q[IB0]);
      r2t0_q     <= AW'(dot_q[IA01]) + AW'(dot_q[IB0]);
      r2t1_q     <= AW'(dot_q[IA11]) + AW'(dot_q[IB1]);
      r6t0_q     <= AW'(dot_q[IA01]) + AW'(dot_q[IB1]);
      r6t1_q     <= AW'(dot_q[IA00]) + AW'(dot_q[IB0]);
      a00_s4_q   <= dot_q[IA00];
      a11_s4_q   <= dot_q[IA11];
      b0_s4_q    <= dot_q[IB0];
      b1_s4_q    <= dot_q[IB1];
      c_s4_q     <= dot_q[IC];
    end
  end

  // stage 5: det, s, t and the first comparisons
  logic signed [WW-1:0]   det_raw;
  logic signed [AW-1:0]   sum_ab0, sum_ab1;
  ptsd_pkg::cmp_t         cmp5_d;
  ptsd_pkg::cmp_t         cmp5_q;
  logic signed [WW-1:0]   det_s5_q, s_s5_q, t_s5_q;
  logic signed [AW-1:0]   r2num_s5_q, r6num_s5_q;
  logic signed [AW-1:0]   q10_s5_q, q01_s5_q, dn_s5_q, r1num_s5_q;
  logic signed [DOTW-1:0] a00_s5_q, a11_s5_q, b0_s5_q, b1_s5_q, c_s5_q;

  assign det_raw = WW'(m_q[0]) - WW'(m_q[1]);
  assign sum_ab0 = AW'(a00_s4_q) + AW'(b0_s4_q);
  assign sum_ab1 = AW'(a11_s4_q) + AW'(b1_s4_q);

  always_comb begin
    cmp5_d            = '0;
    cmp5_d.a00_le_nb0 = sum_ab0[AW-1] || (sum_ab0 == '0);
    cmp5_d.a11_le_nb1 = sum_ab1[AW-1] || (sum_ab1 == '0);
    cmp5_d.r2_lt      = r2t0_q < r2t1_q;
    cmp5_d.r2_t1_le0  = r2t1_q[AW-1] || (r2t1_q == '0);
    cmp5_d.r6_lt      = r6t0_q < r6t1_q;
    cmp5_d.r6_t1_le0  = r6t1_q[AW-1] || (r6t1_q == '0);
    cmp5_d.r1_num_le0 = r1num_s4_q[AW-1] || (r1num_s4_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_s5_q   <= det_raw[WW-1] ? -det_raw : det_raw;
      s_s5_q     <= WW'(m_q[2]) - WW'(m_q[3]);
      t_s5_q     <= WW'(m_q[4]) - WW'(m_q[5]);
      r2num_s5_q <= r2t1_q - r2t0_q;
      r6num_s5_q <= r6t1_q - r6t0_q;
      cmp5_q     <= cmp5_d;
      q10_s5_q   <= q10_s4_q;
      q01_s5_q   <= q01_s4_q;
      dn_s5_q    <= dn_s4_q;
      r1num_s5_q <= r1num_s4_q;
      a00_s5_q   <= a00_s4_q;
      a11_s5_q   <= a11_s4_q;
      b0_s5_q    <= b0_s4_q;
      b1_s5_q    <= b1_s4_q;
      c_s5_q     <= c_s4_q;
    end
  end

  // stage 6: the remaining comparisons
  logic signed [WW:0] st_sum;
  ptsd_pkg::cmp_t     cmp6_d;

  assign st_sum = (WW+1)'(s_s5_q) + (WW+1)'(t_s5_q);

  always_comb begin
    cmp6_d          = cmp5_q;
    cmp6_d.st_le    = st_sum <= (WW+1)'(det_s5_q);
    cmp6_d.det_zero = det_s5_q == '0;
    cmp6_d.r2_dn_le = dn_s5_q <= r2num_s5_q;
    cmp6_d.r6_dn_le = dn_s5_q <= r6num_s5_q;
    cmp6_d.r1_dn_le = dn_s5_q <= r1num_s5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmp_o   <= cmp6_d;
      det_o   <= det_s5_q;
      s_o     <= s_s5_q;
      t_o     <= t_s5_q;
      r2num_o <= r2num_s5_q;
      r6num_o <= r6num_s5_q;
      q10_o   <= q10_s5_q;
      q01_o   <= q01_s5_q;
      dn_o    <= dn_s5_q;
      r1num_o <= r1num_s5_q;
      a00_o   <= a00_s5_q;
      a11_o   <= a11_s5_q;
      b0_o    <= b0_s5_q;
      b1_o    <= b1_s5_q;
      c_o     <= c_s5_q;
    end
  end

endmodule

`default_nettype wire

FILE: design/ptsd_select.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsd_select #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  parameter int NUM_W       = 115,
  parameter int DIV_W       = 74
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  ptsd_pkg::cmp_t                          cmp_i,
  input  logic signed [2*(COORD_WIDTH+1)+2-1:0]   a00_i,
  input  logic signed [2*(COORD_WIDTH+1)+2-1:0]   a11_i,
  input  logic signed [2*(COORD_WIDTH+1)+2-1:0]   b0_i,
  input  logic signed [2*(COORD_WIDTH+1)+2-1:0]   b1_i,
  input  logic signed [2*(COORD_WIDTH+1)+2-1:0]   c_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   q10_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   q01_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   dn_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   r2num_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   r6num_i,
  input  logic signed [2*(COORD_WIDTH+1)+4-1:0]   r1num_i,
  input  logic signed [2*(2*(COORD_WIDTH+1)+2):0] det_i,
  input  logic signed [2*(2*(COORD_WIDTH+1)+2):0] s_i,
  input  logic signed [2*(2*(COORD_WIDTH+1)+2):0] t_i,
  output logic                                    valid_o,
  output ptsd_pkg::info_t                         info_o,
  output logic [NUM_W-1:0]                        num_o,
  output logic [DIV_W-1:0]                        dv_o
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int DOTW = 2 * DW + 2;
  localparam int AW   = DOTW + 2;
  localparam int WW   = 2 * DOTW + 1;
  localparam int LOW  = WW / 2;
  localparam int HIW  = WW - LOW;
  localparam int PHW  = HIW + AW;
  localparam int PLW  = LOW + 1 + AW;
  localparam int PW   = AW + WW + 2;
  localparam int SH_P = (2 * FRAC_BITS <= ptsd_pkg::OUT_FRAC) ?
                        ptsd_pkg::OUT_FRAC - 2 * FRAC_BITS : 0;
  localparam int SH_D = (2 * FRAC_BITS > ptsd_pkg::OUT_FRAC) ?
                        2 * FRAC_BITS - ptsd_pkg::OUT_FRAC : 0;
  localparam int PSW  = PW + SH_P;
  localparam int DSW  = WW + SH_D;
  localparam int NST  = 6;

  typedef enum logic [1:0] {
    K_DIRECT,
    K_EDGE,
    K_FACE
  } kind_e;

  logic [NST-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = v_q[NST-1];

  // stage 7: region decision
  logic signed [AW-1:0] a00_a, a11_a, b0_a, b1_a, c_a;
  logic                 s_neg, t_neg, b0_neg, b1_neg;
  kind_e                kind;
  logic signed [AW-1:0] x_base, e_num, e_den;
  ptsd_pkg::info_t      info_d;

  assign a00_a  = AW'(a00_i);
  assign a11_a  = AW'(a11_i);
  assign b0_a   = AW'(b0_i);
  assign b1_a   = AW'(b1_i);
  assign c_a    = AW'(c_i);
  assign s_neg  = s_i[WW-1];
  assign t_neg  = t_i[WW-1];
  assign b0_neg = b0_i[DOTW-1];
  assign b1_neg = b1_i[DOTW-1];

  always_comb begin
    kind              = K_DIRECT;
    x_base            = c_a;
    e_num             = b0_a;
    e_den             = a00_a;
    info_d.region     = ptsd_pkg::REG_FACE;
    info_d.degenerate = 1'b0;
    if (cmp_i.st_le) begin
      if (s_neg && t_neg && b0_neg) begin
        info_d.region = ptsd_pkg::REG_VERT0;
        if (cmp_i.a00_le_nb0) begin
          x_base = q10_i;
        end else begin
          kind = K_EDGE;
        end
      end else if (s_neg) begin
        info_d.region = t_neg ? ptsd_pkg::REG_VERT0 : ptsd_pkg::REG_EDGE02;
        if (!b1_neg) begin
          x_base = c_a;
        end else if (cmp_i.a11_le_nb1) begin
          x_base = q01_i;
        end else begin
          kind  = K_EDGE;
          e_num = b1_a;
          e_den = a11_a;
        end
      end else if (t_neg) begin
        info_d.region = ptsd_pkg::REG_EDGE01;
        if (!b0_neg) begin
          x_base = c_a;
        end else if (cmp_i.a00_le_nb0) begin
          x_base = q10_i;
        end else begin
          kind = K_EDGE;
        end
      end else begin
        info_d.region = ptsd_pkg::REG_FACE;
        if (cmp_i.det_zero) begin
          info_d.degenerate = 1'b1;
        end else begin
          kind = K_FACE;
        end
      end
    end else if (s_neg) begin
      info_d.region = ptsd_pkg::REG_VERT2;
      if (cmp_i.r2_lt) begin
        if (cmp_i.r2_dn_le) begin
          x_base = q10_i;
        end else begin
          kind   = K_EDGE;
          x_base = q01_i;
          e_num  = r2num_i;
          e_den  = dn_i;
        end
      end else if (cmp_i.r2_t1_le0) begin
        x_base = q01_i;
      end else if (!b1_neg) begin
        x_base = c_a;
      end else begin
        kind  = K_EDGE;
        e_num = b1_a;
        e_den = a11_a;
      end
    end else if (t_neg) begin
      info_d.region = ptsd_pkg::REG_VERT1;
      if (cmp_i.r6_lt) begin
        if (cmp_i.r6_dn_le) begin
          x_base = q01_i;
        end else begin
          kind   = K_EDGE;
          x_base = q10_i;
          e_num  = r6num_i;
          e_den  = dn_i;
        end
      end else if (cmp_i.r6_t1_le0) begin
        x_base = q10_i;
      end else if (!b0_neg) begin
        x_base = c_a;
      end else begin
        kind = K_EDGE;
      end
    end else begin
      info_d.region = ptsd_pkg::REG_EDGE12;
      if (cmp_i.r1_num_le0) begin
        x_base = q01_i;
      end else if (cmp_i.r1_dn_le) begin
        x_base = q10_i;
      end else begin
        kind   = K_EDGE;
        x_base = q01_i;
        e_num  = r1num_i;
        e_den  = dn_i;
      end
    end
  end

  // distance numerator as w0*n0 + w1*n1 + w2*n2 over denominator d
  logic signed [WW-1:0] w_d [3];
  logic signed [AW-1:0] n_d [3];
  logic signed [WW-1:0] d_d;

  always_comb begin
    w_d[0] = {{(WW-1){1'b0}}, 1'b1};
    n_d[0] = x_base;
    w_d[1] = '0;
    n_d[1] = '0;
    w_d[2] = '0;
    n_d[2] = '0;
    d_d    = {{(WW-1){1'b0}}, 1'b1};
    case (kind)
      K_EDGE: begin
        w_d[0] = WW'(e_den);
        w_d[1] = -WW'(e_num);
        n_d[1] = e_num;
        d_d    = WW'(e_den);
      end
      K_FACE: begin
        w_d[0] = det_i;
        n_d[0] = c_a;
        w_d[1] = s_i;
        n_d[1] = b0_a;
        w_d[2] = t_i;
        n_d[2] = b1_a;
        d_d    = det_i;
      end
      default: begin
      end
    endcase
  end

  logic signed [WW-1:0] w_q [3];
  logic signed [AW-1:0] n_q [3];
  logic signed [WW-1:0] d_s7_q, d_s8_q, d_s9_q, d_s10_q, d_s11_q;
  ptsd_pkg::info_t      info_q [6];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k] <= w_d[k];
        n_q[k] <= n_d[k];
      end
      d_s7_q    <= d_d;
      info_q[0] <= info_d;
      for (int i = 1; i < 6; i++) begin
        info_q[i] <= info_q[i-1];
      end
    end
  end

  // stage 8: split wide factor into two partial products
  logic signed [PHW-1:0] ph_q [3];
  logic signed [PLW-1:0] pl_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        ph_q[k] <= PHW'($signed(w_q[k][WW-1:LOW])) * PHW'(n_q[k]);
        pl_q[k] <= PLW'($signed({1'b0, w_q[k][LOW-1:0]})) * PLW'(n_q[k]);
      end
      d_s8_q <= d_s7_q;
    end
  end

  // stage 9: recombine, stage 10: sum of three
  logic signed [PW-1:0] prod_q [3];
  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= (PW'(ph_q[k]) <<< LOW) + PW'(pl_q[k]);
      end
      d_s9_q  <= d_s8_q;
      p_q     <= prod_q[0] + prod_q[1] + prod_q[2];
      d_s10_q <= d_s9_q;
    end
  end

  // stage 11: magnitude, stage 12: rounding numerator and doubled divisor
  logic [PW-1:0]    mag_q;
  logic [PSW-1:0]   p_scaled;
  logic [DSW-1:0]   d_scaled;

  assign p_scaled = PSW'(mag_q) << SH_P;
  assign d_scaled = DSW'(d_s11_q[WW-1:0]) << SH_D;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= p_q[PW-1] ? PW'(-p_q) : PW'(p_q);
      d_s11_q <= d_s10_q;
      num_o   <= (NUM_W'(p_scaled) << 1) + NUM_W'(d_scaled);
      dv_o    <= DIV_W'(d_scaled) << 1;
    end
  end

  assign info_o = info_q[5];

endmodule

`default_nettype wire

FILE: design/ptsd_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module ptsd_divider #(
  parameter int NUM_W = 115,
  parameter int DIV_W = 74
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  ptsd_pkg::info_t                 info_i,
  input  logic [NUM_W-1:0]                num_i,
  input  logic [DIV_W-1:0]                dv_i,
  output logic                            valid_o,
  output ptsd_pkg::info_t                 info_o,
  output logic [ptsd_pkg::OUT_BITS-1:0]   quot_o
);

  localparam int QB = ptsd_pkg::OUT_BITS;
  localparam int RW = DIV_W;

  logic [QB:0]     v_q;
  logic [QB:0]     sat_q;
  ptsd_pkg::info_t info_q [QB+1];
  logic [QB-1:0]   q_q    [QB+1];
  logic [RW-1:0]   rem_q  [QB];
  logic [QB-1:0]   nlo_q  [QB];
  logic [DIV_W-1:0] dv_q  [QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB-1:0], valid_i};
    end
  end

  // head stage: overflow check, the high part seeds the remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0]  <= num_i[NUM_W-1:QB] >= dv_i;
      rem_q[0]  <= RW'(num_i[NUM_W-1:QB]);
      nlo_q[0]  <= num_i[QB-1:0];
      dv_q[0]   <= dv_i;
      q_q[0]    <= '0;
      info_q[0] <= info_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [RW:0] trial;
    logic        ge;

    assign trial = {rem_q[k], nlo_q[k][QB-1-k]};
    assign ge    = trial >= {1'b0, dv_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]    <= {q_q[k][QB-2:0], ge};
        sat_q[k+1]  <= sat_q[k];
        info_q[k+1] <= info_q[k];
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= ge ? RW'(trial - {1'b0, dv_q[k]}) : trial[RW-1:0];
          nlo_q[k+1] <= nlo_q[k];
          dv_q[k+1]  <= dv_q[k];
        end
      end
    end
  end

  assign valid_o = v_q[QB];
  assign info_o  = info_q[QB];
  assign quot_o  = sat_q[QB] ? '1 : q_q[QB];

endmodule

`default_nettype wire

FILE: design/point_triangle_squared_distance_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Squared distance from a point to a triangle, one query per clock while the output is not
// stalled. Each word carries a signed fixed-point point and three vertices; the result is
// the squared distance in unsigned Q18.16 (rounded half up, saturated at all ones), the
// region of the nearest point and a flag for a zero-area face. Fully pipelined: a new word
// is taken every cycle unless a stalled result holds the pipeline; it passes through the six
// setup stages (dot and cross products), six selection and product stages, and the divider,
// which spends one overflow stage plus one stage per quotient bit. A stall on the output holds
// the whole pipeline in place and stalls the input only while a result is waiting.
`include "point_triangle_squared_distance_core_defines.svh"

module point_triangle_squared_distance_core #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic signed [COORD_WIDTH-1:0] v0_x_i,
  input  logic signed [COORD_WIDTH-1:0] v0_y_i,
  input  logic signed [COORD_WIDTH-1:0] v0_z_i,
  input  logic signed [COORD_WIDTH-1:0] v1_x_i,
  input  logic signed [COORD_WIDTH-1:0] v1_y_i,
  input  logic signed [COORD_WIDTH-1:0] v1_z_i,
  input  logic signed [COORD_WIDTH-1:0] v2_x_i,
  input  logic signed [COORD_WIDTH-1:0] v2_y_i,
  input  logic signed [COORD_WIDTH-1:0] v2_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptsd_pkg::OUT_BITS-1:0] squared_distance_o,
  output logic [2:0]                    region_o,
  output logic                          degenerate_o
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int DOTW = 2 * DW + 2;
  localparam int AW   = DOTW + 2;
  localparam int WW   = 2 * DOTW + 1;
  localparam int PW   = AW + WW + 2;
  localparam int SH_P = (2 * FRAC_BITS <= ptsd_pkg::OUT_FRAC) ?
                        ptsd_pkg::OUT_FRAC - 2 * FRAC_BITS : 0;
  localparam int SH_D = (2 * FRAC_BITS > ptsd_pkg::OUT_FRAC) ?
                        2 * FRAC_BITS - ptsd_pkg::OUT_FRAC : 0;
  localparam int PSW  = PW + SH_P;
  localparam int DSW  = WW + SH_D;
  localparam int NUMW = ((PSW > DSW) ? PSW : DSW) + 2;
  localparam int DIVW = DSW + 1;

  logic en;

  // whole pipeline moves unless a finished word is held up
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  logic                   su_valid;
  ptsd_pkg::cmp_t         su_cmp;
  logic signed [DOTW-1:0] su_a00, su_a11, su_b0, su_b1, su_c;
  logic signed [AW-1:0]   su_q10, su_q01, su_dn, su_r2num, su_r6num, su_r1num;
  logic signed [WW-1:0]   su_det, su_s, su_t;

  ptsd_setup #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .v0_x_i   (v0_x_i),
    .v0_y_i   (v0_y_i),
    .v0_z_i   (v0_z_i),
    .v1_x_i   (v1_x_i),
    .v1_y_i   (v1_y_i),
    .v1_z_i   (v1_z_i),
    .v2_x_i   (v2_x_i),
    .v2_y_i   (v2_y_i),
    .v2_z_i   (v2_z_i),
    .valid_o  (su_valid),
    .cmp_o    (su_cmp),
    .a00_o    (su_a00),
    .a11_o    (su_a11),
    .b0_o     (su_b0),
    .b1_o     (su_b1),
    .c_o      (su_c),
    .q10_o    (su_q10),
    .q01_o    (su_q01),
    .dn_o     (su_dn),
    .r2num_o  (su_r2num),
    .r6num_o  (su_r6num),
    .r1num_o  (su_r1num),
    .det_o    (su_det),
    .s_o      (su_s),
    .t_o      (su_t)
  );

  logic              se_valid;
  ptsd_pkg::info_t   se_info;
  logic [NUMW-1:0]   se_num;
  logic [DIVW-1:0]   se_dv;

  ptsd_select #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .NUM_W      (NUMW),
    .DIV_W      (DIVW)
  ) u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(su_valid),
    .cmp_i  (su_cmp),
    .a00_i  (su_a00),
    .a11_i  (su_a11),
    .b0_i   (su_b0),
    .b1_i   (su_b1),
    .c_i    (su_c),
    .q10_i  (su_q10),
    .q01_i  (su_q01),
    .dn_i   (su_dn),
    .r2num_i(su_r2num),
    .r6num_i(su_r6num),
    .r1num_i(su_r1num),
    .det_i  (su_det),
    .s_i    (su_s),
    .t_i    (su_t),
    .valid_o(se_valid),
    .info_o (se_info),
    .num_o  (se_num),
    .dv_o   (se_dv)
  );

  ptsd_pkg::info_t dv_info;

  ptsd_divider #(
    .NUM_W(NUMW),
    .DIV_W(DIVW)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(se_valid),
    .info_i (se_info),
    .num_i  (se_num),
    .dv_i   (se_dv),
    .valid_o(out_valid_o),
    .info_o (dv_info),
    .quot_o (squared_distance_o)
  );

  assign region_o     = dv_info.region;
  assign degenerate_o = dv_info.degenerate;

  `PTSD_ASSERT_IMPL(a_degen_is_face, out_valid_o && degenerate_o, region_o == ptsd_pkg::REG_FACE)
  `PTSD_ASSERT_IMPL(a_empty_never_stalls, !out_valid_o, !in_stall_o)

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 16;
  localparam int PIPE_DEPTH = 47;
  localparam int N_RANDOM = 1230;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] ax, ay, az;
    logic signed [CW-1:0] bx, by, bz;
    logic signed [CW-1:0] cx, cy, cz;
  } query_t;

  typedef struct packed {
    logic [ptsd_pkg::OUT_BITS-1:0] sqd;
    ptsd_pkg::region_e             region;
    logic                          degen;
  } dist_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  query_t cur_q = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ptsd_pkg::OUT_BITS-1:0] squared_distance_o;
  logic [2:0] region_o;
  logic degenerate_o;

  query_t query_q[$];
  dist_t dist_expect_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_degen = 0;
  int region_hits[7];
  logic in_taken = 1'b0;

  always #5 clk_i = ~clk_i;

  point_triangle_squared_distance_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .point_x_i(cur_q.px), .point_y_i(cur_q.py), .point_z_i(cur_q.pz),
    .v0_x_i(cur_q.ax), .v0_y_i(cur_q.ay), .v0_z_i(cur_q.az),
    .v1_x_i(cur_q.bx), .v1_y_i(cur_q.by), .v1_z_i(cur_q.bz),
    .v2_x_i(cur_q.cx), .v2_y_i(cur_q.cy), .v2_z_i(cur_q.cz),
    .out_valid_o, .out_stall_i, .squared_distance_o, .region_o, .degenerate_o
  );

  function automatic wide_t dot3(wide_t x0, wide_t x1, wide_t x2, wide_t y0, wide_t y1,
                                 wide_t y2);
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  function automatic dist_t predict_distance(query_t q);
    wide_t e0x, e0y, e0z, e1x, e1y, e1z, dx, dy, dz;
    wide_t a00, a01, a11, b0, b1, c, det, s, t, q10, q01, p, d, dn, num, t0, t1, quo;
    dist_t r;
    e0x = wide_t'(q.bx) - wide_t'(q.ax);
    e0y = wide_t'(q.by) - wide_t'(q.ay);
    e0z = wide_t'(q.bz) - wide_t'(q.az);
    e1x = wide_t'(q.cx) - wide_t'(q.ax);
    e1y = wide_t'(q.cy) - wide_t'(q.ay);
    e1z = wide_t'(q.cz) - wide_t'(q.az);
    dx = wide_t'(q.ax) - wide_t'(q.px);
    dy = wide_t'(q.ay) - wide_t'(q.py);
    dz = wide_t'(q.az) - wide_t'(q.pz);
    a00 = dot3(e0x, e0y, e0z, e0x, e0y, e0z);
    a01 = dot3(e0x, e0y, e0z, e1x, e1y, e1z);
    a11 = dot3(e1x, e1y, e1z, e1x, e1y, e1z);
    b0 = dot3(dx, dy, dz, e0x, e0y, e0z);
    b1 = dot3(dx, dy, dz, e1x, e1y, e1z);
    c = dot3(dx, dy, dz, dx, dy, dz);
    det = a00 * a11 - a01 * a01;
    if (det < 0) det = -det;
    s = a01 * b1 - a11 * b0;
    t = a01 * b0 - a00 * b1;
    q10 = a00 + 2 * b0 + c;
    q01 = a11 + 2 * b1 + c;
    p = c;
    d = wide_t'(1);
    r.degen = 1'b0;
    if (s + t <= det) begin
      if (s < 0 && t < 0 && b0 < 0) begin
        r.region = ptsd_pkg::REG_VERT0;
        if (a00 <= -b0) p = q10;
        else begin p = c * a00 - b0 * b0; d = a00; end
      end else if (s < 0) begin
        r.region = (t < 0) ? ptsd_pkg::REG_VERT0 : ptsd_pkg::REG_EDGE02;
        if (b1 >= 0) p = c;
        else if (a11 <= -b1) p = q01;
        else begin p = c * a11 - b1 * b1; d = a11; end
      end else if (t < 0) begin
        r.region = ptsd_pkg::REG_EDGE01;
        if (b0 >= 0) p = c;
        else if (a00 <= -b0) p = q10;
        else begin p = c * a00 - b0 * b0; d = a00; end
      end else begin
        r.region = ptsd_pkg::REG_FACE;
        if (det == 0) r.degen = 1'b1;
        else begin p = c * det + s * b0 + t * b1; d = det; end
      end
    end else begin
      dn = a00 - 2 * a01 + a11;
      if (s < 0) begin
        r.region = ptsd_pkg::REG_VERT2;
        t0 = a01 + b0;
        t1 = a11 + b1;
        if (t0 < t1) begin
          num = t1 - t0;
          if (dn <= num) p = q10;
          else begin p = q01 * dn - num * num; d = dn; end
        end else if (t1 <= 0) p = q01;
        else if (b1 >= 0) p = c;
        else begin p = c * a11 - b1 * b1; d = a11; end
      end else if (t < 0) begin
        r.region = ptsd_pkg::REG_VERT1;
        t0 = a01 + b1;
        t1 = a00 + b0;
        if (t0 < t1) begin
          num = t1 - t0;
          if (dn <= num) p = q01;
          else begin p = q10 * dn - num * num; d = dn; end
        end else if (t1 <= 0) p = q10;
        else if (b0 >= 0) p = c;
        else begin p = c * a00 - b0 * b0; d = a00; end
      end else begin
        r.region = ptsd_pkg::REG_EDGE12;
        num = a11 + b1 - a01 - b0;
        if (num <= 0) p = q01;
        else if (dn <= num) p = q10;
        else begin p = q01 * dn - num * num; d = dn; end
      end
    end
    if (p < 0) p = -p;
    // inputs carry 8 fraction bits, so p already has the 16 the output wants
    quo = (2 * p + d) / (2 * d);
    if (quo >= (wide_t'(1) <<< ptsd_pkg::OUT_BITS)) r.sqd = '1;
    else r.sqd = quo[ptsd_pkg::OUT_BITS-1:0];
    return r;
  endfunction

  function automatic query_t mk(int px, int py, int pz, int ax, int ay, int az, int bx, int by,
                                int bz, int cx, int cy, int cz);
    query_t q;
    q.px = CW'(px); q.py = CW'(py); q.pz = CW'(pz);
    q.ax = CW'(ax); q.ay = CW'(ay); q.az = CW'(az);
    q.bx = CW'(bx); q.by = CW'(by); q.bz = CW'(bz);
    q.cx = CW'(cx); q.cy = CW'(cy); q.cz = CW'(cz);
    return q;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom_range(0, 1023) - 512);
      1: return CW'($urandom_range(0, 65535) - 32768);
      default: return CW'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  // sender: bursts of words with gaps, plus a full drain every few hundred words
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      logic want;
      want = 1'b0;
      if (in_taken) void'(query_q.pop_front());
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (query_q.size() != 0 &&
                 !(n_sent % 300 == 150 && dist_expect_q.size() != 0)) begin
          want = 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid_i <= want;
        if (want) cur_q <= query_q[0];
      end
    end
  end

  // receiver stall pattern switches among four styles: none, sparse random, dense random and a regular square wave
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= (stall_cnt % 8 < 4);
    endcase
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o && rst_ni;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      dist_expect_q.push_back(predict_distance(cur_q));
      n_sent <= n_sent + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dist_expect_q.size() == 0) begin
        $error("result word with nothing expected");
        errors = errors + 1;
      end else begin
        dist_t e;
        e = dist_expect_q.pop_front();
        n_checked <= n_checked + 1;
        region_hits[e.region] <= region_hits[e.region] + 1;
        if (e.degen) n_degen <= n_degen + 1;
        if (&e.sqd) n_sat <= n_sat + 1;
        if (squared_distance_o !== e.sqd) begin
          $error("squared_distance expected %0d got %0d", e.sqd, squared_distance_o);
          errors = errors + 1;
        end
        if (region_o !== e.region) begin
          $error("region expected %0d got %0d", e.region, region_o);
          errors = errors + 1;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate expected %0d got %0d", e.degen, degenerate_o);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    int mode;
    query_t q;
    for (int i = 0; i < 7; i++) region_hits[i] = 0;
    // reference triangle in the z = 0 plane, one point per region
    query_q.push_back(mk(64, 64, 256, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(256, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(-64, 512, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(-256, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(-256, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(128, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(512, -64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    query_q.push_back(mk(300, 300, 300, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    // zero-area faces
    query_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    query_q.push_back(mk(5, -7, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    query_q.push_back(mk(100, 50, 3, 0, 0, 0, 256, 256, 0, 512, 512, 0));
    query_q.push_back(mk(7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7));
    // extremes, saturation
    query_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, -32768));
    query_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767,
                         -32768, 32767, 32767));
    query_q.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768,
                         -32768, -32768, 32767));
    query_q.push_back(mk(-1, -1, -1, -1, -1, -1, 32767, -1, -1, -1, 32767, -1));
    query_q.push_back(mk(1, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1));
    query_q.push_back(mk(-32768, 0, 32767, 0, 0, 0, -32768, 32767, 0, 32767, -32768, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 2);
      q = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
           rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
      // occasionally collapse the triangle to a segment or a point
      case ($urandom_range(0, 19))
        0: begin q.bx = q.ax; q.by = q.ay; q.bz = q.az; end
        1: begin q.cx = q.ax; q.cy = q.ay; q.cz = q.az; q.bx = q.ax; q.by = q.ay;
             q.bz = q.az; end
        2: begin q.cx = CW'(q.ax + 2 * (q.bx - q.ax)); q.cy = CW'(q.ay + 2 * (q.by - q.ay));
             q.cz = CW'(q.az + 2 * (q.bz - q.az)); end
        default: ;
      endcase
      query_q.push_back(q);
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (query_q.size() == 0);
    wait (dist_expect_q.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    $display("sent %0d queries, checked %0d results, %0d saturated, %0d degenerate",
             n_sent, n_checked, n_sat, n_degen);
    $display("region counts: %0d %0d %0d %0d %0d %0d %0d", region_hits[0], region_hits[1],
             region_hits[2], region_hits[3], region_hits[4], region_hits[5], region_hits[6]);
    if (errors == 0 && dist_expect_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
